// ===== rtl/rlm_pkg.sv =====
// shared types, widths and constants of the rms level meter
package rlm_pkg;

  localparam int COUNT_BITS = 20;
  localparam int SUM_W      = COUNT_BITS + 31;
  localparam int FRAC_W     = 24;
  localparam int EXP_W      = $clog2(SUM_W);
  localparam int LOG_W      = EXP_W + FRAC_W;
  localparam int MANT_W     = 32;
  localparam int SQ_W       = 31;
  localparam int K_W        = 29;
  localparam int MPROD_W    = LOG_W + 1 + K_W + 1;
  localparam int LEVEL_W    = 12;
  localparam int ITER_W     = $clog2(FRAC_W);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  // 100*log10(2) in q.24
  localparam logic [K_W-1:0]        TENTHS_PER_LOG2 = K_W'(505044526);
  // 30 in q.24, full scale squared is 2^30
  localparam logic [LOG_W:0]        FS_LOG = (LOG_W+1)'(30) << FRAC_W;
  localparam logic [MPROD_W-1:0]    ROUND_HALF = MPROD_W'(1) << 47;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_END    = 1'b1
  } op_t;

  typedef struct packed {
    logic               op;
    logic signed [15:0] sample;
    logic               silent;
  } in_item_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] level_tenths_db;
    logic                      no_samples;
    logic                      minus_infinity;
  } out_item_t;

  typedef enum logic [1:0] {
    L_IDLE,
    L_NORM,
    L_SQ,
    L_ADJ
  } log_state_t;

  typedef enum logic [2:0] {
    T_IDLE,
    T_LSUM_GO,
    T_LSUM_WAIT,
    T_LCNT_GO,
    T_LCNT_WAIT,
    T_MUL,
    T_FIN
  } top_state_t;

endpackage

// ===== rtl/rlm_accum.sv =====
// square-sum accumulator and saturating sample counter
module rlm_accum (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           smp_en,
  input  logic signed [15:0]             smp,
  input  logic                           smp_silent,
  input  logic                           clr,
  output logic [rlm_pkg::SUM_W-1:0]      sum,
  output logic [rlm_pkg::COUNT_BITS-1:0] cnt,
  output logic                           busy
);

  logic [rlm_pkg::SUM_W-1:0]      sum_r, sum_nxt;
  logic [rlm_pkg::COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [rlm_pkg::SQ_W-1:0]       sq_r, sq_nxt;
  logic                           pend_r, pend_nxt;
  logic signed [31:0]             prod;

  assign prod = smp * smp;

  always_comb begin
    sum_nxt  = sum_r;
    cnt_nxt  = cnt_r;
    sq_nxt   = sq_r;
    pend_nxt = 1'b0;
    if (pend_r) begin
      sum_nxt = sum_r + rlm_pkg::SUM_W'(sq_r);
    end
    if (clr) begin
      sum_nxt = '0;
      cnt_nxt = '0;
    end else if (smp_en && cnt_r != rlm_pkg::COUNT_MAX) begin
      cnt_nxt  = cnt_r + 1'b1;
      sq_nxt   = smp_silent ? '0 : prod[rlm_pkg::SQ_W-1:0];
      pend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      sum_r  <= sum_nxt;
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
    end
    sq_r <= sq_nxt;
  end

  assign sum  = sum_r;
  assign cnt  = cnt_r;
  assign busy = pend_r;

endmodule

// ===== rtl/rlm_log2.sv =====
// serial log2 unit: bit-wise normalise, then one fraction bit per squaring
module rlm_log2 (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rlm_pkg::SUM_W-1:0] x,
  output logic                      done,
  output logic [rlm_pkg::LOG_W-1:0] result
);

  rlm_pkg::log_state_t state_r, state_nxt;
  logic [rlm_pkg::SUM_W-1:0]    norm_r, norm_nxt;
  logic [rlm_pkg::EXP_W-1:0]    n_r, n_nxt;
  logic [rlm_pkg::MANT_W-1:0]   y_r, y_nxt;
  logic [2*rlm_pkg::MANT_W-1:0] prod_r, prod_nxt;
  logic [rlm_pkg::FRAC_W-1:0]   frac_r, frac_nxt;
  logic [rlm_pkg::ITER_W-1:0]   it_r, it_nxt;
  logic                         done_r, done_nxt;
  logic [rlm_pkg::MANT_W:0]     t;

  assign t = prod_r[2*rlm_pkg::MANT_W-1 -: rlm_pkg::MANT_W+1];

  always_comb begin
    state_nxt = state_r;
    norm_nxt  = norm_r;
    n_nxt     = n_r;
    y_nxt     = y_r;
    prod_nxt  = prod_r;
    frac_nxt  = frac_r;
    it_nxt    = it_r;
    done_nxt  = 1'b0;
    case (state_r)
      rlm_pkg::L_IDLE: begin
        if (start) begin
          norm_nxt  = x;
          n_nxt     = rlm_pkg::EXP_W'(rlm_pkg::SUM_W - 1);
          frac_nxt  = '0;
          it_nxt    = '0;
          state_nxt = rlm_pkg::L_NORM;
        end
      end
      rlm_pkg::L_NORM: begin
        if (norm_r[rlm_pkg::SUM_W-1]) begin
          y_nxt     = norm_r[rlm_pkg::SUM_W-1 -: rlm_pkg::MANT_W];
          state_nxt = rlm_pkg::L_SQ;
        end else begin
          norm_nxt = norm_r << 1;
          n_nxt    = n_r - 1'b1;
        end
      end
      rlm_pkg::L_SQ: begin
        prod_nxt  = y_r * y_r;
        state_nxt = rlm_pkg::L_ADJ;
      end
      rlm_pkg::L_ADJ: begin
        if (t[rlm_pkg::MANT_W]) begin
          y_nxt    = t[rlm_pkg::MANT_W:1];
          frac_nxt = {frac_r[rlm_pkg::FRAC_W-2:0], 1'b1};
        end else begin
          y_nxt    = t[rlm_pkg::MANT_W-1:0];
          frac_nxt = {frac_r[rlm_pkg::FRAC_W-2:0], 1'b0};
        end
        it_nxt = it_r + 1'b1;
        if (it_r == rlm_pkg::ITER_W'(rlm_pkg::FRAC_W - 1)) begin
          done_nxt  = 1'b1;
          state_nxt = rlm_pkg::L_IDLE;
        end else begin
          state_nxt = rlm_pkg::L_SQ;
        end
      end
      default: state_nxt = rlm_pkg::L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rlm_pkg::L_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    norm_r <= norm_nxt;
    n_r    <= n_nxt;
    y_r    <= y_nxt;
    prod_r <= prod_nxt;
    frac_r <= frac_nxt;
    it_r   <= it_nxt;
  end

  assign done   = done_r;
  assign result = {n_r, frac_r};

endmodule

// ===== rtl/rms_level_meter_dbfs.sv =====
// rms level meter top level: accumulator, report sequencer and result register
// sample transfer: square register, then 51-bit add; input stalls while the add is pending
// interval end with report: log2 of the sum, then of the count, then multiply and finish
//   (one bit shift per cycle to normalise; square and adjust for each of 24 fraction bits)
// interval end with nothing to compute or reporting off: handled from the idle state
// synchronous active-low reset clears the square sum, counter, control and sets report_enable
module rms_level_meter_dbfs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rlm_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rlm_pkg::out_item_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);

  // configuration
  logic report_en_r;

  // sequencer
  rlm_pkg::top_state_t state_r, state_nxt;
  logic                           in_acc;
  logic                           smp_acc;
  logic                           end_acc;
  logic [rlm_pkg::SUM_W-1:0]      sum;
  logic [rlm_pkg::COUNT_BITS-1:0] cnt;
  logic                           acc_busy;

  // snapshot of the closed interval
  logic [rlm_pkg::SUM_W-1:0]      sum_snap_r, sum_snap_nxt;
  logic [rlm_pkg::COUNT_BITS-1:0] cnt_snap_r, cnt_snap_nxt;
  logic [rlm_pkg::LOG_W-1:0]      ls_r, ls_nxt;
  logic [rlm_pkg::LOG_W:0]        lc;
  logic [rlm_pkg::LOG_W:0]        m;
  logic [rlm_pkg::MPROD_W-1:0]    mprod_r, mprod_nxt;
  logic [rlm_pkg::LEVEL_W-1:0]    tenths;

  // log2 unit
  logic                      log_start;
  logic [rlm_pkg::SUM_W-1:0] log_x;
  logic                      log_done;
  logic [rlm_pkg::LOG_W-1:0] log_res;

  // result register
  logic               out_valid_r, out_valid_nxt;
  rlm_pkg::out_item_t out_data_r, out_data_nxt;

  // an interval end waits for a free result register
  assign in_stall = acc_busy | (state_r != rlm_pkg::T_IDLE)
                  | ((in_data.op == rlm_pkg::OP_END) & out_valid_r);
  assign in_acc  = in_valid & ~in_stall;
  assign smp_acc = in_acc & (in_data.op == rlm_pkg::OP_SAMPLE);
  assign end_acc = in_acc & (in_data.op == rlm_pkg::OP_END);

  rlm_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .smp_en     (smp_acc),
    .smp        (in_data.sample),
    .smp_silent (in_data.silent),
    .clr        (end_acc),
    .sum        (sum),
    .cnt        (cnt),
    .busy       (acc_busy)
  );

  assign log_start = (state_r == rlm_pkg::T_LSUM_GO) | (state_r == rlm_pkg::T_LCNT_GO);
  assign log_x     = (state_r == rlm_pkg::T_LCNT_GO)
                   ? rlm_pkg::SUM_W'(cnt_snap_r) : sum_snap_r;

  rlm_log2 u_log2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (log_start),
    .x      (log_x),
    .done   (log_done),
    .result (log_res)
  );

  // level difference, clamped at full scale
  assign lc     = (rlm_pkg::LOG_W+1)'(log_res) + rlm_pkg::FS_LOG;
  assign m      = (lc > (rlm_pkg::LOG_W+1)'(ls_r)) ? lc - (rlm_pkg::LOG_W+1)'(ls_r) : '0;
  assign tenths = mprod_r[48 +: rlm_pkg::LEVEL_W];

  always_comb begin
    state_nxt     = state_r;
    sum_snap_nxt  = sum_snap_r;
    cnt_snap_nxt  = cnt_snap_r;
    ls_nxt        = ls_r;
    mprod_nxt     = mprod_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      rlm_pkg::T_IDLE: begin
        if (end_acc && report_en_r) begin
          out_data_nxt = '0;
          if (cnt == '0) begin
            out_data_nxt.no_samples = 1'b1;
            out_valid_nxt           = 1'b1;
          end else if (sum == '0) begin
            out_data_nxt.minus_infinity = 1'b1;
            out_valid_nxt               = 1'b1;
          end else begin
            sum_snap_nxt = sum;
            cnt_snap_nxt = cnt;
            state_nxt    = rlm_pkg::T_LSUM_GO;
          end
        end
      end
      rlm_pkg::T_LSUM_GO:   state_nxt = rlm_pkg::T_LSUM_WAIT;
      rlm_pkg::T_LSUM_WAIT: begin
        if (log_done) begin
          ls_nxt    = log_res;
          state_nxt = rlm_pkg::T_LCNT_GO;
        end
      end
      rlm_pkg::T_LCNT_GO:   state_nxt = rlm_pkg::T_LCNT_WAIT;
      rlm_pkg::T_LCNT_WAIT: begin
        if (log_done) begin
          state_nxt = rlm_pkg::T_MUL;
        end
      end
      rlm_pkg::T_MUL: begin
        // log_res still holds the count's log2 here
        mprod_nxt = rlm_pkg::MPROD_W'(m) * rlm_pkg::MPROD_W'(rlm_pkg::TENTHS_PER_LOG2);
        state_nxt = rlm_pkg::T_FIN;
      end
      rlm_pkg::T_FIN: begin
        mprod_nxt                    = mprod_r;
        out_data_nxt                 = '0;
        out_data_nxt.level_tenths_db = rlm_pkg::LEVEL_W'(0) - tenths;
        out_valid_nxt                = 1'b1;
        state_nxt                    = rlm_pkg::T_IDLE;
      end
      default: state_nxt = rlm_pkg::T_IDLE;
    endcase
  end

  // rounding offset is added to the product as it is written into the product register
  logic [rlm_pkg::MPROD_W-1:0] mprod_rnd;
  assign mprod_rnd = (state_r == rlm_pkg::T_MUL) ? mprod_nxt + rlm_pkg::ROUND_HALF : mprod_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rlm_pkg::T_IDLE;
      out_valid_r <= 1'b0;
      report_en_r <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        report_en_r <= cfg_wdata;
      end
    end
    sum_snap_r <= sum_snap_nxt;
    cnt_snap_r <= cnt_snap_nxt;
    ls_r       <= ls_nxt;
    mprod_r    <= mprod_rnd;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
